// ===== src/sorted_key_list_engine_macros.svh =====
`ifndef SORTED_KEY_LIST_ENGINE_MACROS_SVH
`define SORTED_KEY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SKLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SKLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/skle_pkg.sv =====
`default_nettype none

package skle_pkg;

  localparam int OP_W  = 3;
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int CNT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_REMLAST = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

  // input tdata layout
  localparam int IN_OP_LSB  = 0;
  localparam int IN_KEY_LSB = IN_OP_LSB + OP_W;
  localparam int IN_PAY_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_BITS    = IN_PAY_LSB + PAY_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_BITS    = 1 + CNT_W + 1 + 1 + KEY_W + PAY_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/skle_ram.sv =====
`default_nettype none

// entry store: one write port, one read port, registered read data
module skle_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int EW    = 64
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [EW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [EW-1:0] rd_data
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/sorted_key_list_engine.sv =====
// answers: append, remove last, unknown opcodes, dump of an empty list, insert into a full
// list and remove by key from an empty one go straight to the status state; otherwise
// sorted insert and remove by key walk the list; dump: first entry after the read register
// and output register, then one entry per cycle while out_tready; one request at a time
// reset: synchronous active-low rst_n empties the list; the entry memory is not cleared
`default_nettype none

module sorted_key_list_engine #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input transactions
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [2:0] opcode, [34:3] key, [66:35] payload, [71:67] zero
  input  wire logic [skle_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result transactions
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] ok, [7:1] count, [8] is_full, [9] is_empty, [41:10] entry_key,
  // [73:42] entry_payload, [79:74] zero
  output logic [skle_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast
);

`include "sorted_key_list_engine_macros.svh"

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (PAYLOAD_BITS < skle_pkg::PAY_W) ? PAYLOAD_BITS : skle_pkg::PAY_W;
  localparam int EW = skle_pkg::KEY_W + PW;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam int PAD_W = skle_pkg::OUT_TDATA_W - skle_pkg::OUT_BITS;

  // controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;
  localparam logic [1:0] ST_STAT = 2'd3;

  // input field split
  logic [skle_pkg::OP_W-1:0]         in_op;
  logic signed [skle_pkg::KEY_W-1:0] in_key;
  logic [skle_pkg::PAY_W-1:0]        in_pay;

  assign in_op  = in_tdata[skle_pkg::IN_OP_LSB  +: skle_pkg::OP_W];
  assign in_key = in_tdata[skle_pkg::IN_KEY_LSB +: skle_pkg::KEY_W];
  assign in_pay = in_tdata[skle_pkg::IN_PAY_LSB +: skle_pkg::PAY_W];

  // control and working registers
  logic [1:0]                        state_r, state_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [CW-1:0]                     idx_r, idx_nxt;
  logic                              is_ins_r, is_ins_nxt;
  logic                              found_r, found_nxt;
  logic                              ok_r, ok_nxt;
  logic signed [skle_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]                     pay_r, pay_nxt;
  logic [EW-1:0]                     carry_r, carry_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [skle_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                              out_last_r, out_last_nxt;
  logic                              out_free;
  logic                              out_load;

  // memory port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic signed [skle_pkg::KEY_W-1:0] rd_key;
  logic [PW-1:0]                     rd_pay;
  logic                              in_fire;
  logic                              at_end;
  logic [CW-1:0]                     idx_inc;
  logic                              cnt_full;
  logic                              cnt_empty;

  // entries pack as {payload, key}
  assign rd_key = rd_data[skle_pkg::KEY_W-1:0];
  assign rd_pay = rd_data[EW-1:skle_pkg::KEY_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign at_end    = (idx_r == cnt_r);
  assign idx_inc   = idx_r + CW'(1);
  assign cnt_full  = (cnt_r == CAP_C);
  assign cnt_empty = (cnt_r == '0);

  skle_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .EW    (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // the walk reads entry idx+1 while writing idx (insert) or idx-1 (remove),
  // so a read never meets a write to the same entry and no forwarding is needed
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    is_ins_nxt    = is_ins_r;
    found_nxt     = found_r;
    ok_nxt        = ok_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    carry_nxt     = carry_r;
    out_load      = 1'b0;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = {pay_r, key_r};
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_key;
          pay_nxt   = in_pay[PW-1:0];
          idx_nxt   = '0;
          found_nxt = 1'b0;
          ok_nxt    = 1'b0;
          state_nxt = ST_STAT;
          unique case (in_op)
            skle_pkg::OP_INSERT: begin
              if (!cnt_full) begin
                is_ins_nxt = 1'b1;
                rd_en      = !cnt_empty;
                state_nxt  = ST_WALK;
              end
            end
            skle_pkg::OP_APPEND: begin
              if (!cnt_full) begin
                wr_en   = 1'b1;
                wr_data = {in_pay[PW-1:0], in_key};
                cnt_nxt = cnt_r + CW'(1);
                ok_nxt  = 1'b1;
              end
            end
            skle_pkg::OP_REMOVE: begin
              if (!cnt_empty) begin
                is_ins_nxt = 1'b0;
                rd_en      = 1'b1;
                state_nxt  = ST_WALK;
              end
            end
            skle_pkg::OP_REMLAST: begin
              if (!cnt_empty) begin
                cnt_nxt = cnt_r - CW'(1);
                ok_nxt  = 1'b1;
              end
            end
            skle_pkg::OP_DUMP: begin
              if (!cnt_empty) begin
                rd_en     = 1'b1;
                state_nxt = ST_DUMP;
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (!at_end) begin
          // rd_data holds entry idx
          if (is_ins_r) begin
            if (found_r) begin
              wr_en     = 1'b1;
              wr_addr   = idx_r[AW-1:0];
              wr_data   = carry_r;
              carry_nxt = rd_data;
            end else if (!(rd_key < key_r)) begin
              wr_en     = 1'b1;
              wr_addr   = idx_r[AW-1:0];
              carry_nxt = rd_data;
              found_nxt = 1'b1;
            end
          end else begin
            if (found_r) begin
              // close the gap: entry idx moves down one place
              wr_en   = 1'b1;
              wr_addr = AW'(idx_r - CW'(1));
              wr_data = rd_data;
            end else if (rd_key == key_r) begin
              found_nxt = 1'b1;
            end
          end
          idx_nxt = idx_inc;
          rd_en   = (idx_inc < cnt_r);
          rd_addr = idx_inc[AW-1:0];
        end else begin
          state_nxt = ST_STAT;
          if (is_ins_r) begin
            // tail slot takes the displaced entry, or the new one if none was displaced
            wr_en   = 1'b1;
            wr_addr = cnt_r[AW-1:0];
            wr_data = found_r ? carry_r : {pay_r, key_r};
            cnt_nxt = cnt_r + CW'(1);
            ok_nxt  = 1'b1;
          end else begin
            ok_nxt = found_r;
            if (found_r) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
        end
      end

      ST_DUMP: begin
        // rd_data holds entry idx and stays put while the output is stalled
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = {PAD_W'(0), skle_pkg::PAY_W'(rd_pay), rd_key,
                          1'b0, cnt_full, skle_pkg::CNT_W'(cnt_r), 1'b1};
          out_last_nxt = (idx_inc == cnt_r);
          if (idx_inc == cnt_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_inc;
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end

      ST_STAT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = {PAD_W'(0), skle_pkg::PAY_W'(0), skle_pkg::KEY_W'(0),
                          cnt_empty, cnt_full, skle_pkg::CNT_W'(cnt_r), ok_r};
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    is_ins_r   <= is_ins_nxt;
    found_r    <= found_nxt;
    ok_r       <= ok_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    carry_r    <= carry_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks on the controller
  `SKLE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CAP_C, "entry count above capacity")
  `SKLE_ASSERT_IMP(a_dump_no_write, state_r == ST_DUMP, !wr_en, "memory write during dump")
  `SKLE_ASSERT_IMP(a_walk_idx, state_r == ST_WALK, idx_r <= cnt_r, "walk index past list end")
  `SKLE_ASSERT_NXT(a_accept_busy, in_fire, state_r != ST_IDLE, "accepted item left no work")

endmodule

`default_nettype wire

// ===== sim/tb_sorted_key_list_engine.sv =====
`default_nettype none

module tb_sorted_key_list_engine;

  localparam int CAPACITY     = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 100;

  // opcodes the block does not define, answered with a failed status
  localparam logic [skle_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [skle_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [skle_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic                       ok;
    logic [skle_pkg::CNT_W-1:0] count;
    logic                       full;
    logic                       empty;
    logic [skle_pkg::KEY_W-1:0] key;
    logic [skle_pkg::PAY_W-1:0] payload;
    logic                       last;
  } list_answer_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [skle_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [skle_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;

  // shadow copy of the list, advanced at each accepted transaction
  logic signed [skle_pkg::KEY_W-1:0] list_keys [CAPACITY];
  logic [skle_pkg::PAY_W-1:0]        list_pays [CAPACITY];
  int                                list_len = 0;

  list_answer_t pending_answers [$];
  int           mismatches = 0;
  int           stall_cycles = 0;
  bit           no_idle = 1'b0;

  sorted_key_list_engine #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (skle_pkg::PAY_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_answer(input logic ok,
                                      input logic [skle_pkg::KEY_W-1:0] key,
                                      input logic [skle_pkg::PAY_W-1:0] pay,
                                      input logic last);
    list_answer_t a;
    a.ok      = ok;
    a.count   = list_len[skle_pkg::CNT_W-1:0];
    a.full    = (list_len == CAPACITY);
    a.empty   = (list_len == 0);
    a.key     = key;
    a.payload = pay;
    a.last    = last;
    pending_answers.push_back(a);
  endfunction

  function automatic void place_entry(input int pos,
                                      input logic signed [skle_pkg::KEY_W-1:0] key,
                                      input logic [skle_pkg::PAY_W-1:0] pay);
    int k;
    for (k = list_len; k > pos; k--) begin
      list_keys[k] = list_keys[k-1];
      list_pays[k] = list_pays[k-1];
    end
    list_keys[pos] = key;
    list_pays[pos] = pay;
    list_len++;
  endfunction

  // expected answers of one list operation
  function automatic void predict_list_op(input logic [skle_pkg::OP_W-1:0] op,
                                          input logic signed [skle_pkg::KEY_W-1:0] key,
                                          input logic [skle_pkg::PAY_W-1:0] pay);
    int  pos;
    int  k;
    logic ok;
    ok = 1'b0;
    case (op)
      skle_pkg::OP_INSERT: begin
        if (list_len < CAPACITY) begin
          pos = 0;
          while (pos < list_len && list_keys[pos] < key) pos++;
          place_entry(pos, key, pay);
          ok = 1'b1;
        end
      end
      skle_pkg::OP_APPEND: begin
        if (list_len < CAPACITY) begin
          place_entry(list_len, key, pay);
          ok = 1'b1;
        end
      end
      skle_pkg::OP_REMOVE: begin
        pos = 0;
        while (pos < list_len && list_keys[pos] != key) pos++;
        if (pos < list_len) begin
          for (k = pos; k + 1 < list_len; k++) begin
            list_keys[k] = list_keys[k+1];
            list_pays[k] = list_pays[k+1];
          end
          list_len--;
          ok = 1'b1;
        end
      end
      skle_pkg::OP_REMLAST: begin
        if (list_len > 0) begin
          list_len--;
          ok = 1'b1;
        end
      end
      skle_pkg::OP_DUMP: begin
        if (list_len == 0) begin
          push_answer(1'b0, '0, '0, 1'b1);
        end else begin
          for (k = 0; k < list_len; k++)
            push_answer(1'b1, list_keys[k], list_pays[k], k + 1 == list_len);
        end
        return;
      end
      default: ;
    endcase
    push_answer(ok, '0, '0, 1'b1);
  endfunction

  // sender gaps, skipped during the steady stretch
  task automatic maybe_idle_input();
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_list_op(input logic [skle_pkg::OP_W-1:0] op,
                              input logic [skle_pkg::KEY_W-1:0] key,
                              input logic [skle_pkg::PAY_W-1:0] pay);
    maybe_idle_input();
    in_tdata  <= {{(skle_pkg::IN_TDATA_W - skle_pkg::IN_BITS){1'b0}}, pay, key, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_list_op(op, key, pay);
  endtask

  function automatic logic [skle_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [skle_pkg::PAY_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [skle_pkg::OP_W-1:0] pick_reserved_op();
    case ($urandom_range(0, 2))
      0:       return OP_RSVD5;
      1:       return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  // dump, remove and remove last on an empty list fail or dump a single empty marker
  task automatic test_empty_list();
    send_list_op(skle_pkg::OP_DUMP, '0, '0);
    send_list_op(skle_pkg::OP_REMOVE, 32'h0000_0005, '0);
    send_list_op(skle_pkg::OP_REMLAST, '0, '0);
  endtask

  task automatic test_basic_ops();
    send_list_op(skle_pkg::OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    send_list_op(skle_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_list_op(skle_pkg::OP_INSERT, 32'h0000_0000, 32'h1111_1111);
    // equal key lands in front of the existing one
    send_list_op(skle_pkg::OP_INSERT, 32'h0000_0000, 32'h2222_2222);
    // append ignores ordering
    send_list_op(skle_pkg::OP_APPEND, 32'hffff_ffff, 32'h5555_aaaa);
    send_list_op(skle_pkg::OP_DUMP, '0, '0);
    send_list_op(skle_pkg::OP_REMOVE, 32'h0000_0007, '0);
    // first match of a duplicated key goes
    send_list_op(skle_pkg::OP_REMOVE, 32'h0000_0000, '0);
    send_list_op(skle_pkg::OP_REMLAST, '0, '0);
    send_list_op(OP_RSVD5, 32'h1234_5678, 32'h9abc_def0);
    send_list_op(OP_RSVD6, '0, '0);
    send_list_op(OP_RSVD7, '1, '1);
    send_list_op(skle_pkg::OP_DUMP, '0, '0);
  endtask

  // fill to capacity, hit the full limits, then drain back to empty
  task automatic test_full_list();
    int i;
    for (i = 0; list_len < CAPACITY; i++)
      send_list_op((i % 2) ? skle_pkg::OP_APPEND : skle_pkg::OP_INSERT, pick_key(),
                   pick_payload());
    send_list_op(skle_pkg::OP_INSERT, pick_key(), pick_payload());
    send_list_op(skle_pkg::OP_APPEND, pick_key(), pick_payload());
    send_list_op(skle_pkg::OP_DUMP, '0, '0);
    send_list_op(skle_pkg::OP_REMOVE, list_keys[20], '0);
    for (i = 0; list_len > 0; i++)
      send_list_op((i % 2) ? skle_pkg::OP_REMLAST : skle_pkg::OP_REMOVE, list_keys[0], '0);
    send_list_op(skle_pkg::OP_REMOVE, 32'h8000_0000, '0);
    send_list_op(skle_pkg::OP_DUMP, '0, '0);
  endtask

  // list size swings between growing and shrinking windows
  task automatic test_random_ops(input int n_items);
    int                         i;
    int                         roll;
    int                         grow_pct;
    logic [skle_pkg::OP_W-1:0]  op;
    logic [skle_pkg::KEY_W-1:0] key;
    for (i = 0; i < n_items; i++) begin
      no_idle  = (i >= n_items / 3 && i < n_items / 2);
      grow_pct = ((i / 50) % 2 == 0) ? 70 : 30;
      roll     = $urandom_range(0, 99);
      key      = pick_key();
      if (roll < 5) begin
        op = skle_pkg::OP_DUMP;
      end else if (roll < 8) begin
        op = pick_reserved_op();
      end else if ($urandom_range(0, 99) < grow_pct) begin
        op = ($urandom_range(0, 2) == 0) ? skle_pkg::OP_APPEND : skle_pkg::OP_INSERT;
      end else if ($urandom_range(0, 3) == 0) begin
        op = skle_pkg::OP_REMLAST;
      end else begin
        op = skle_pkg::OP_REMOVE;
        if (list_len > 0 && $urandom_range(0, 3) != 0)
          key = list_keys[$urandom_range(0, list_len - 1)];
      end
      send_list_op(op, key, pick_payload());
    end
    no_idle = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin : check_answers
    list_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_answers.pop_front();
        check_field("ok", want.ok, out_tdata[0]);
        check_field("count", want.count, out_tdata[7:1]);
        check_field("is_full", want.full, out_tdata[8]);
        check_field("is_empty", want.empty, out_tdata[9]);
        check_field("entry_key", want.key, out_tdata[41:10]);
        check_field("entry_payload", want.payload, out_tdata[73:42]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("sorted_key_list_engine test failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_ops(230);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_key_list_engine test passed");
    end else begin
      $display("sorted_key_list_engine test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/skle_pkg.sv
src/skle_ram.sv
src/sorted_key_list_engine.sv
sim/tb_sorted_key_list_engine.sv
